@@ hw/rtl/tdpt_pkg.sv @@
// shared types and constants for the trial division prime test
`default_nettype none

package tdpt_pkg;

    // divisor count that marks a prime
    localparam logic [1:0] PRIME_COUNT = 2'd2;
    // capped count once more than two divisors are seen
    localparam logic [1:0] COUNT_CAP   = 2'd3;

    // status from the serial remainder unit
    typedef struct packed {
        logic done;
        logic rem_zero;
    } rem_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/tdpt_rem.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none

module tdpt_rem #(
    parameter int W = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [W-1:0]          dividend,
    input  wire logic [W-1:0]          divisor,
    output tdpt_pkg::rem_status_t      status
);

    localparam int CNT_W = $clog2(W + 1);
    localparam logic [CNT_W-1:0] STEPS    = CNT_W'(W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(1);

    logic [W-1:0]     shift_reg, shift_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             active_reg, active_next;
    logic             done_reg, done_next;

    logic [W:0]       trial;
    logic [W:0]       diff;

    // partial remainder shifted left with the next dividend bit
    assign trial = {rem_reg, shift_reg[W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (start)
        begin
            shift_next  = dividend;
            div_next    = divisor;
            rem_next    = '0;
            cnt_next    = STEPS;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            // no borrow: subtract, otherwise keep the shifted value
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
            end
            else
            begin
                rem_next = trial[W-1:0];
            end
            shift_next = {shift_reg[W-2:0], 1'b0};
            cnt_next   = cnt_reg - LAST_CNT;
            if (cnt_reg == LAST_CNT)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

`default_nettype wire

@@ hw/rtl/trial_division_prime_test.sv @@
// top level of the trial division prime test
`default_nettype none

// usage
//   a beat is taken at a rising edge with start high and busy low; value
//   carries the number to test, only its low VALUE_WIDTH bits count
//   one result beat follows per input: done is high for exactly one cycle
//   with is_prime, divisor_count and input_valid; the receiver cannot stall
//   and the result must be taken in that cycle
//   candidate divisors d run from 1 while d*d <= value; each one takes a
//   check step and then a bit-serial remainder pass over VALUE_WIDTH bits
//   in the serial remainder unit, and busy is held over the whole scan,
//   done cycle included; a third divisor ends the scan early, in the cycle
//   after that divide; zero gives its result beat in the cycle right after
//   the accept
//   busy stays high from the accept to the done cycle, one item at a time,
//   and the next beat can be taken in the cycle after done
//   reset returns the block to idle with no result pending

module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output      logic                   busy,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output      logic                   done,
    output      logic                   is_prime,
    output      logic [1:0]             divisor_count,
    output      logic                   input_valid
);

    localparam int W    = VALUE_WIDTH;
    localparam int SQ_W = 2 * VALUE_WIDTH;

    // controller states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [W-1:0]    x_reg, x_next;          // number under test
    logic [W-1:0]    d_reg, d_next;          // current trial divisor
    logic [SQ_W-1:0] sq_reg, sq_next;        // square of the trial divisor
    logic [1:0]      count_reg, count_next;  // divisors found, capped
    logic            valid_reg, valid_next;

    logic [SQ_W-1:0] x_ext;
    logic            in_range;
    logic            rem_start;
    logic [2:0]      count_sum;
    tdpt_pkg::rem_status_t rem_status;

    assign x_ext    = {{(SQ_W - W){1'b0}}, x_reg};
    assign in_range = (sq_reg <= x_ext);
    assign rem_start = (state_reg == ST_CHECK) && in_range;

    // a divisor equal to its pair counts once, otherwise twice
    assign count_sum = {1'b0, count_reg} + ((sq_reg == x_ext) ? 3'd1 : 3'd2);

    tdpt_rem #(
        .W (W)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (x_reg),
        .divisor  (d_reg),
        .status   (rem_status)
    );

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x_next     = value;
                    d_next     = {{(W - 1){1'b0}}, 1'b1};
                    sq_next    = {{(SQ_W - 1){1'b0}}, 1'b1};
                    count_next = 2'd0;
                    // zero has no divisors to scan and is flagged invalid
                    if (value == '0)
                    begin
                        valid_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                // past the square root every divisor has been paired
                if (in_range)
                begin
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_status.done)
                begin
                    state_next = ST_CHECK;
                    if (rem_status.rem_zero)
                    begin
                        if (count_sum > {1'b0, tdpt_pkg::PRIME_COUNT})
                        begin
                            // early stop on a third divisor
                            count_next = tdpt_pkg::COUNT_CAP;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            count_next = count_sum[1:0];
                        end
                    end
                    // (d+1)^2 = d^2 + 2d + 1
                    d_next  = d_reg + {{(W - 1){1'b0}}, 1'b1};
                    sq_next = sq_reg + {{(SQ_W - W - 1){1'b0}}, d_reg, 1'b1};
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        count_reg <= count_next;
        valid_reg <= valid_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = (state_reg == ST_DONE);
    assign divisor_count = count_reg;
    assign is_prime      = (count_reg == tdpt_pkg::PRIME_COUNT);
    assign input_valid   = valid_reg;

`ifndef SYNTHESIS
    // a result beat follows an accepted beat or work in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result beat without an item in flight");

    // an accepted beat always makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start work");

    // zero input reports no divisors
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !input_valid) |-> (divisor_count == 2'd0 && !is_prime))
        else $error("zero input reported divisors");

    // the remainder unit only finishes while a divide is pending
    a_rem_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        rem_status.done |-> (state_reg == ST_DIVIDE))
        else $error("remainder finished outside a divide");
`endif

endmodule

`default_nettype wire
